// ===== rtl/core/tpm_pkg.sv =====
package tpm_pkg;

	// Default sizes handed to the top level parameters
	localparam int NODE_COUNT_DEF   = 4096;
	localparam int LIST_DEPTH_DEF   = 4;
	localparam int ADDRESS_BITS_DEF = 32;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_POOL_FULL = 2'd1;
	localparam logic [1:0] ST_LIST_FULL = 2'd2;

	// Kind of a single closing result
	typedef enum logic [1:0] {
		EK_OK,
		EK_POOL,
		EK_LIST,
		EK_MISS
	} emit_kind_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       ready;       // input side may transfer
		logic       rd_trie;     // read child and count stores at the current node
		logic       rd_ent;      // read a list entry
		logic       ent_best;    // list entry address uses the best node
		logic       step_child;  // move to the existing child
		logic       alloc_link;  // link the next free node into the parent slot
		logic       alloc_init;  // clear the new node and move to it
		logic       mark_best;   // remember the node if its list is non-empty
		logic       idx_inc;     // advance the list index
		logic       list_add;    // append the country to the current list
		logic       emit_done;   // load a closing result of kind emit_kind
		logic       emit_hit;    // load a matched country result
		emit_kind_t emit_kind;
	} tpm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic in_valid;
		logic in_action;
		logic ins_end;    // insert walk reached the prefix length
		logic lk_end;     // lookup walk used all address bits
		logic slot_zero;  // chosen child is absent
		logic pool_full;
		logic idx_end;    // list index reached the list count
		logic list_full;
		logic ent_match;
		logic have;       // lookup saw a non-empty list
		logic hit_last;
		logic out_free;
	} tpm_sts_t;

endpackage

// ===== rtl/core/tpm_req_if.sv =====
interface tpm_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] address;
	logic [5:0]  prefix_len;
	logic [7:0]  country;

	modport source (output valid, action, address, prefix_len, country, input ready);
	modport sink (input valid, action, address, prefix_len, country, output ready);
endinterface

// ===== rtl/core/tpm_rsp_if.sv =====
interface tpm_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       found;
	logic [7:0] country_out;
	logic       last;

	modport source (output valid, status, found, country_out, last, input ready);
	modport sink (input valid, status, found, country_out, last, output ready);
endinterface

// ===== rtl/core/ipv4_trie_prefix_match.sv =====
// Channel  Dir  Payload                                  Transfer
// req      in   action, address, prefix_len, country     valid && ready
// rsp      out  status, found, country_out, last         valid && ready
//
// Steps from the req transfer to the result load: each trie level is a registered
// node store read, then an evaluate; each new node adds an allocate step. An
// insert walks L prefix bits, allocating N new nodes, then compares up to E list
// entries, stopping early on a duplicate. A lookup walks up to L levels, then ends
// on a miss or reads out its R results in turn. Idle comes before the next transfer.
// One item is in flight at a time; a new one is taken while the last result waits.
// Reset clears the root node and sets the free pointer to node 1; nodes are cleared when
// allocated, so no clearing pass is needed. A stalled rsp holds the walk.
module ipv4_trie_prefix_match
	import tpm_pkg::*;
#(
	parameter int NODE_COUNT   = NODE_COUNT_DEF,
	parameter int LIST_DEPTH   = LIST_DEPTH_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tpm_req_if.sink   req,
	tpm_rsp_if.source rsp
);

	tpm_cmd_t cmd;
	tpm_sts_t sts;

	tpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	tpm_dp #(
		.NODE_COUNT   (NODE_COUNT),
		.LIST_DEPTH   (LIST_DEPTH),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ===== rtl/core/tpm_ctrl.sv =====
module tpm_ctrl
	import tpm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  tpm_sts_t sts,
	output tpm_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_I_RD,
		S_I_EV,
		S_I_AL,
		S_L_CHK,
		S_L_EV,
		S_K_RD,
		S_K_EV,
		S_K_DONE,
		S_O_RD,
		S_O_EM,
		S_EMIT
	} state_t;

	state_t     state_q, state_d;
	emit_kind_t kind_q, kind_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		cmd.emit_kind = kind_q;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (sts.in_valid) begin
					state_d = sts.in_action ? S_K_RD : S_I_RD;
				end
			end
			S_I_RD: begin
				cmd.rd_trie = 1'b1;
				state_d = S_I_EV;
			end
			S_I_EV: begin
				if (sts.ins_end) begin
					state_d = S_L_CHK;
				end else if (!sts.slot_zero) begin
					cmd.step_child = 1'b1;
					state_d = S_I_RD;
				end else if (sts.pool_full) begin
					kind_d  = EK_POOL;
					state_d = S_EMIT;
				end else begin
					cmd.alloc_link = 1'b1;
					state_d = S_I_AL;
				end
			end
			S_I_AL: begin
				cmd.alloc_init = 1'b1;
				state_d = S_I_RD;
			end
			S_L_CHK: begin
				if (sts.idx_end) begin
					if (sts.list_full) begin
						kind_d = EK_LIST;
					end else begin
						cmd.list_add = 1'b1;
						kind_d = EK_OK;
					end
					state_d = S_EMIT;
				end else begin
					cmd.rd_ent = 1'b1;
					state_d = S_L_EV;
				end
			end
			S_L_EV: begin
				if (sts.ent_match) begin
					kind_d  = EK_OK;
					state_d = S_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_L_CHK;
				end
			end
			S_K_RD: begin
				cmd.rd_trie = 1'b1;
				state_d = S_K_EV;
			end
			S_K_EV: begin
				cmd.mark_best = 1'b1;
				if (sts.lk_end || sts.slot_zero) begin
					state_d = S_K_DONE;
				end else begin
					cmd.step_child = 1'b1;
					state_d = S_K_RD;
				end
			end
			S_K_DONE: begin
				if (sts.have) begin
					state_d = S_O_RD;
				end else begin
					kind_d  = EK_MISS;
					state_d = S_EMIT;
				end
			end
			S_O_RD: begin
				cmd.rd_ent   = 1'b1;
				cmd.ent_best = 1'b1;
				state_d = S_O_EM;
			end
			S_O_EM: begin
				if (sts.out_free) begin
					cmd.emit_hit = 1'b1;
					if (sts.hit_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_O_RD;
					end
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and pending result kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= EK_OK;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

// ===== rtl/core/tpm_dp.sv =====
module tpm_dp
	import tpm_pkg::*;
#(
	parameter int NODE_COUNT   = NODE_COUNT_DEF,
	parameter int LIST_DEPTH   = LIST_DEPTH_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	tpm_req_if.sink        req,
	tpm_rsp_if.source      rsp,
	input  tpm_cmd_t       cmd,
	output tpm_sts_t       sts
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam int DW = $clog2(ADDRESS_BITS + 1);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int ENT_DEPTH = 1 << (NW + IW);

	// Trie and list stores
	logic [NW-1:0] c0_mem [0:NODE_COUNT-1];
	logic [NW-1:0] c1_mem [0:NODE_COUNT-1];
	logic [CW-1:0] cnt_mem [0:NODE_COUNT-1];
	logic [7:0]    ent_mem [0:ENT_DEPTH-1];
	logic [NW-1:0] c0_rd, c1_rd;
	logic [CW-1:0] cnt_rd;
	logic [7:0]    ent_rd;

	// Root node lives in flops so reset clears it
	logic [NW-1:0] root_c0_q, root_c1_q;
	logic [CW-1:0] root_cnt_q;

	// Walk registers
	logic [NW-1:0] node_q, best_q;
	logic [DW-1:0] depth_q, plen_q;
	logic [31:0]   addr_q;
	logic [7:0]    cc_q;
	logic [NW:0]   nf_q;
	logic [CW-1:0] idx_q, bestcnt_q;
	logic          have_q;

	// Result register
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic          out_found_q;
	logic [7:0]    out_country_q;
	logic          out_last_q;

	logic          load;
	logic          root;
	logic [4:0]    bit_pos;
	logic          bit_s;
	logic [NW-1:0] cur_c0, cur_c1, slot;
	logic [CW-1:0] cur_cnt, n_eff;
	logic [NW-1:0] trie_addr, ent_node;
	logic [NW+IW-1:0] ent_raddr, ent_waddr;
	logic          c0_we, c1_we, cnt_we;
	logic [NW-1:0] link_wd;
	logic [CW-1:0] cnt_wd;
	logic          out_free;

	assign load     = req.valid & cmd.ready;
	assign req.ready = cmd.ready;
	assign root     = (node_q == '0);
	assign bit_pos  = 5'(ADDRESS_BITS - 1) - 5'(depth_q);
	assign bit_s    = addr_q[bit_pos];
	assign cur_c0   = root ? root_c0_q : c0_rd;
	assign cur_c1   = root ? root_c1_q : c1_rd;
	assign cur_cnt  = root ? root_cnt_q : cnt_rd;
	assign slot     = bit_s ? cur_c1 : cur_c0;
	assign n_eff    = (cur_cnt > CW'(LIST_DEPTH)) ? CW'(LIST_DEPTH) : cur_cnt;
	assign out_free = !out_valid_q || rsp.ready;

	// Store addresses and write enables
	assign trie_addr = cmd.alloc_init ? nf_q[NW-1:0] : node_q;
	assign ent_node  = cmd.ent_best ? best_q : node_q;
	assign ent_raddr = {ent_node, idx_q[IW-1:0]};
	assign ent_waddr = {node_q, n_eff[IW-1:0]};
	assign link_wd   = cmd.alloc_init ? '0 : nf_q[NW-1:0];
	assign c0_we     = cmd.alloc_init | (cmd.alloc_link & !root & !bit_s);
	assign c1_we     = cmd.alloc_init | (cmd.alloc_link & !root & bit_s);
	assign cnt_we    = cmd.alloc_init | (cmd.list_add & !root);
	assign cnt_wd    = cmd.alloc_init ? '0 : n_eff + CW'(1);

	always_ff @(posedge clk) begin
		if (c0_we) begin
			c0_mem[trie_addr] <= link_wd;
		end
		if (cmd.rd_trie) begin
			c0_rd <= c0_mem[trie_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (c1_we) begin
			c1_mem[trie_addr] <= link_wd;
		end
		if (cmd.rd_trie) begin
			c1_rd <= c1_mem[trie_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[trie_addr] <= cnt_wd;
		end
		if (cmd.rd_trie) begin
			cnt_rd <= cnt_mem[trie_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.list_add) begin
			ent_mem[ent_waddr] <= cc_q;
		end
		if (cmd.rd_ent) begin
			ent_rd <= ent_mem[ent_raddr];
		end
	end

	// Control state: root node, free pointer, match flag, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_c0_q   <= '0;
			root_c1_q   <= '0;
			root_cnt_q  <= '0;
			nf_q        <= (NW+1)'(1);
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.alloc_link && root && !bit_s) begin
				root_c0_q <= nf_q[NW-1:0];
			end
			if (cmd.alloc_link && root && bit_s) begin
				root_c1_q <= nf_q[NW-1:0];
			end
			if (cmd.list_add && root) begin
				root_cnt_q <= n_eff + CW'(1);
			end
			if (cmd.alloc_init) begin
				nf_q <= nf_q + (NW+1)'(1);
			end
			if (load) begin
				have_q <= 1'b0;
			end else if (cmd.mark_best && cur_cnt != '0) begin
				have_q <= 1'b1;
			end
			if (cmd.emit_done || cmd.emit_hit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers: capture item, advance node and depth
	always_ff @(posedge clk) begin
		if (load) begin
			addr_q  <= req.address;
			cc_q    <= req.country;
			plen_q  <= (req.prefix_len > 6'(ADDRESS_BITS)) ? DW'(ADDRESS_BITS)
				: DW'(req.prefix_len);
			node_q  <= '0;
			depth_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.step_child) begin
				node_q  <= slot;
				depth_q <= depth_q + DW'(1);
			end else if (cmd.alloc_init) begin
				node_q  <= nf_q[NW-1:0];
				depth_q <= depth_q + DW'(1);
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
		end
		if (cmd.mark_best && cur_cnt != '0) begin
			best_q    <= node_q;
			bestcnt_q <= n_eff;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit_hit) begin
			out_status_q  <= ST_OK;
			out_found_q   <= 1'b1;
			out_country_q <= ent_rd;
			out_last_q    <= sts.hit_last;
		end else if (cmd.emit_done) begin
			case (cmd.emit_kind)
				EK_POOL: out_status_q <= ST_POOL_FULL;
				EK_LIST: out_status_q <= ST_LIST_FULL;
				default: out_status_q <= ST_OK;
			endcase
			out_found_q   <= 1'b0;
			out_country_q <= '0;
			out_last_q    <= 1'b1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found       = out_found_q;
	assign rsp.country_out = out_country_q;
	assign rsp.last        = out_last_q;

	// Status to the controller
	always_comb begin
		sts.in_valid  = req.valid;
		sts.in_action = req.action;
		sts.ins_end   = (depth_q == plen_q);
		sts.lk_end    = (depth_q == DW'(ADDRESS_BITS));
		sts.slot_zero = (slot == '0);
		sts.pool_full = (nf_q >= (NW+1)'(NODE_COUNT));
		sts.idx_end   = (idx_q == n_eff);
		sts.list_full = (n_eff == CW'(LIST_DEPTH));
		sts.ent_match = (ent_rd == cc_q);
		sts.have      = have_q;
		sts.hit_last  = ((CW+1)'(idx_q) + (CW+1)'(1) == (CW+1)'(bestcnt_q));
		sts.out_free  = out_free;
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_done || cmd.emit_hit) |-> out_free)
		else $error("result loaded over a pending result");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_link |=> (cmd.alloc_init && nf_q < (NW+1)'(NODE_COUNT)))
		else $error("node allocated with the pool full");

	a_nf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= (NW+1)'(NODE_COUNT) && nf_q != '0)
		else $error("free node pointer out of range");

	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.list_add |-> (!sts.list_full && sts.idx_end))
		else $error("country added to a full list");

endmodule

// ===== verif/ipv4_trie_prefix_match_tb.sv =====
`timescale 1ns / 100ps

module ipv4_trie_prefix_match_tb
	import tpm_pkg::*;
();

	localparam int NODES = 4096;
	localparam int LDEPTH = 4;
	localparam int ABITS = 32;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [7:0] country_out;
		logic       last;
	} match_rsp_t;

	logic clk;
	logic arst_n;
	tpm_req_if req ();
	tpm_rsp_if rsp ();

	ipv4_trie_prefix_match DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Shadow trie
	int unsigned trie_zero [NODES];
	int unsigned trie_one [NODES];
	int unsigned node_cnt [NODES];
	logic [7:0] node_list [NODES][LDEPTH];
	int unsigned free_node;

	match_rsp_t rsp_queue [$];
	int unsigned err_count;
	int unsigned idle_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Addresses used by inserts, reused for lookups to hit stored prefixes
	logic [31:0] prefix_pool [$];

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic addr_bit(logic [31:0] a, int unsigned d);
		return a[ABITS - 1 - d];
	endfunction

	// Model an insert and return its status
	function automatic logic [1:0] trie_insert(logic [31:0] a, int unsigned plen,
		logic [7:0] cc);
		int unsigned node;
		int unsigned nxt;
		int unsigned n;
		node = 0;
		if (plen > ABITS)
			plen = ABITS;
		for (int unsigned i = 0; i < plen; i++) begin
			nxt = addr_bit(a, i) ? trie_one[node] : trie_zero[node];
			if (nxt == 0) begin
				if (free_node >= NODES)
					return ST_POOL_FULL;
				nxt = free_node;
				if (addr_bit(a, i))
					trie_one[node] = nxt;
				else
					trie_zero[node] = nxt;
				trie_zero[nxt] = 0;
				trie_one[nxt] = 0;
				node_cnt[nxt] = 0;
				free_node++;
			end
			node = nxt;
		end
		n = node_cnt[node];
		for (int unsigned i = 0; i < n; i++)
			if (node_list[node][i] == cc)
				return ST_OK;
		if (n >= LDEPTH)
			return ST_LIST_FULL;
		node_list[node][n] = cc;
		node_cnt[node] = n + 1;
		return ST_OK;
	endfunction

	// Model a lookup and queue its results
	task automatic trie_lookup(logic [31:0] a);
		int unsigned node;
		int unsigned nxt;
		int unsigned best;
		bit have;
		match_rsp_t r;
		node = 0;
		best = 0;
		have = 0;
		for (int unsigned i = 0; i <= ABITS; i++) begin
			if (node_cnt[node] != 0) begin
				best = node;
				have = 1;
			end
			if (i == ABITS)
				break;
			nxt = addr_bit(a, i) ? trie_one[node] : trie_zero[node];
			if (nxt == 0)
				break;
			node = nxt;
		end
		if (!have) begin
			r = '{status: ST_OK, found: 1'b0, country_out: 8'd0, last: 1'b1};
			rsp_queue.push_back(r);
		end else begin
			for (int unsigned i = 0; i < node_cnt[best]; i++) begin
				r = '{status: ST_OK, found: 1'b1, country_out: node_list[best][i],
					last: (i + 1 == node_cnt[best])};
				rsp_queue.push_back(r);
			end
		end
	endtask

	// Send one request and predict its results; valid stays high for a back to back item
	task automatic send_item(logic act, logic [31:0] a, logic [5:0] plen, logic [7:0] cc);
		match_rsp_t r;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.address <= a;
		req.prefix_len <= plen;
		req.country <= cc;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (act == ACT_INSERT) begin
			r = '{status: trie_insert(a, plen, cc), found: 1'b0, country_out: 8'd0,
				last: 1'b1};
			rsp_queue.push_back(r);
			prefix_pool.push_back(a);
		end else begin
			trie_lookup(a);
		end
		@(negedge clk);
	endtask

	task automatic wait_drain();
		req.valid <= 1'b0;
		while (rsp_queue.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// Drive ready at the falling edge
	always @(negedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
	end

	// Check each result transfer
	always @(posedge clk) begin
		match_rsp_t got;
		match_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{status: rsp.status, found: rsp.found, country_out: rsp.country_out,
				last: rsp.last};
			if (rsp_queue.size() == 0) begin
				$display("%0t unexpected result %p", $time, got);
				err_count++;
			end else begin
				want = rsp_queue.pop_front();
				if (got !== want) begin
					$display("%0t mismatch expected %p actual %p", $time, want, got);
					err_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] near_prefix();
		logic [31:0] a;
		if (prefix_pool.size() == 0)
			return $urandom;
		a = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
		// flip a few low bits so walks diverge at various depths
		return a ^ ($urandom & ((32'h1 << $urandom_range(31)) - 1));
	endfunction

	task automatic test_directed();
		send_item(ACT_LOOKUP, 32'h0000_0000, 6'd0, 8'd0);
		send_item(ACT_INSERT, 32'h0000_0000, 6'd0, 8'd7);
		send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF);
		send_item(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF);
		send_item(ACT_INSERT, 32'h0000_0000, 6'd63, 8'h00);
		send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0);
		send_item(ACT_LOOKUP, 32'h0000_0000, 6'd0, 8'd0);
		send_item(ACT_LOOKUP, 32'hFFFF_FFFE, 6'd0, 8'd0);
		// fill one list, then duplicate and overflow it
		send_item(ACT_INSERT, 32'hC0A8_0000, 6'd16, 8'd1);
		send_item(ACT_INSERT, 32'hC0A8_0000, 6'd16, 8'd2);
		send_item(ACT_INSERT, 32'hC0A8_0000, 6'd16, 8'd3);
		send_item(ACT_INSERT, 32'hC0A8_0000, 6'd16, 8'd2);
		send_item(ACT_INSERT, 32'hC0A8_0000, 6'd16, 8'd200);
		send_item(ACT_INSERT, 32'hC0A8_0000, 6'd16, 8'd99);
		send_item(ACT_LOOKUP, 32'hC0A8_1234, 6'd0, 8'd0);
		send_item(ACT_INSERT, 32'hC0A8_1200, 6'd24, 8'd5);
		send_item(ACT_LOOKUP, 32'hC0A8_12AB, 6'd0, 8'd0);
		send_item(ACT_LOOKUP, 32'hC0A8_13AB, 6'd0, 8'd0);
		send_item(ACT_LOOKUP, 32'h5555_AAAA, 6'd0, 8'd0);
	endtask

	task automatic test_random(int unsigned count);
		logic [31:0] a;
		for (int unsigned k = 0; k < count; k++) begin
			a = ($urandom_range(3) == 0) ? $urandom : near_prefix();
			if ($urandom_range(1))
				send_item(ACT_INSERT, a, $urandom_range(4) == 0 ? $urandom_range(63) :
					$urandom_range(8, 28), $urandom_range(3) == 0 ? $urandom : $urandom_range(7));
			else
				send_item(ACT_LOOKUP, a, $urandom, $urandom);
		end
	endtask

	// Exhaust the pool with long distinct prefixes
	task automatic test_pool_full();
		while (free_node < NODES)
			send_item(ACT_INSERT, $urandom, 6'd32, $urandom);
		for (int k = 0; k < 6; k++) begin
			send_item(ACT_INSERT, $urandom, 6'd32, $urandom);
			send_item(ACT_LOOKUP, near_prefix(), 6'd0, 8'd0);
		end
	endtask

	initial begin
		err_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		free_node = 1;
		for (int i = 0; i < NODES; i++) begin
			trie_zero[i] = 0;
			trie_one[i] = 0;
			node_cnt[i] = 0;
		end
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_INSERT;
		req.address = '0;
		req.prefix_len = '0;
		req.country = '0;
		rsp.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(80);
		send_idle_pct = 47;
		test_random(80);
		// hold off until all results arrive
		wait_drain();
		send_idle_pct = 0;
		recv_stall_pct = 47;
		test_random(80);
		send_idle_pct = 23;
		recv_stall_pct = 23;
		test_random(70);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_pool_full();

		wait_drain();
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tpm_pkg.sv
rtl/core/tpm_req_if.sv
rtl/core/tpm_rsp_if.sv
rtl/core/tpm_ctrl.sv
rtl/core/tpm_dp.sv
rtl/core/ipv4_trie_prefix_match.sv
verif/ipv4_trie_prefix_match_tb.sv
